[hdl/dmtl_pkg.sv]
// Shared types and constants for the delayed message timer list.
package dmtl_pkg;

    // Default sizing of the store.
    localparam int SLOTS_DEF       = 32;
    localparam int HANDLE_BITS_DEF = 16;

    // Input item modes.
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Result status codes.
    localparam logic STATUS_DELIVER = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;

    // One input item.
    typedef struct packed {
        logic        mode;
        logic [3:0]  src_id;
        logic [3:0]  dst_id;
        logic [15:0] message_handle;
        logic [30:0] delay_ticks;
    } dmtl_in_t;

    // One result item.
    typedef struct packed {
        logic        status;
        logic [3:0]  out_src_id;
        logic [3:0]  out_dst_id;
        logic [15:0] out_handle;
        logic        last;
    } dmtl_out_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FULL,
        ST_WALK,
        ST_WALK_END
    } dmtl_state_t;

endpackage

[hdl/dmtl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module dmtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dmtl_pkg::SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/delayed_message_timer_list.sv]
// Top level of the delayed message timer list: sequencer, link memory and entry memory.
// A list of up to SLOTS pending messages lives in two RAMs: a link memory holding each
// slot's successor (shared by the pending list and the free list) and an entry memory
// holding each slot's tick count and payload. An insert into a full store waits for the
// result register to report the drop. A tick walks the pending list, each step following
// the successor pointer just read from the link memory, whose read data is registered.
// Expiry results are held one step so the final one can carry last; the walk pauses on
// an expiry while a result is held and the result register is full and not being taken.
// The block accepts a new item only between items, but a finished result may
// still be waiting.
module delayed_message_timer_list #(
    parameter int SLOTS       = dmtl_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = dmtl_pkg::HANDLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dmtl_pkg::dmtl_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output dmtl_pkg::dmtl_out_t result
);

    localparam int IW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = 32 + 8 + HANDLE_BITS;
    localparam logic [IW-1:0] NULL_IDX = IW'(SLOTS);

    // Control and payload registers.
    dmtl_pkg::dmtl_state_t state_reg, state_next;
    dmtl_pkg::dmtl_in_t    item_reg, item_next;
    dmtl_pkg::dmtl_out_t   pend_reg, pend_next;
    dmtl_pkg::dmtl_out_t   result_reg, result_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         free_head_reg, free_head_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         prev_reg, prev_next;
    logic                  fix_pend_reg, fix_pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  result_valid_reg, result_valid_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [AW-1:0]         rd_addr_reg;
    logic                  rd_valid_reg;

    // Memory ports.
    logic [AW-1:0] rd_addr;
    logic          link_wr_en;
    logic [AW-1:0] link_wr_addr;
    logic [IW-1:0] link_wr_data;
    logic [IW-1:0] link_ram_q;
    logic          ent_wr_en;
    logic [AW-1:0] ent_wr_addr;
    logic [EW-1:0] ent_wr_data;
    logic [EW-1:0] ent_ram_q;

    // Datapath values.
    logic [IW-1:0]            link_rd;
    logic [31:0]              ticks_dec;
    logic                     expire;
    logic                     out_free;
    logic                     stall;
    logic [HANDLE_BITS+15:0]  in_handle_ext;
    logic [HANDLE_BITS+15:0]  out_handle_ext;
    dmtl_pkg::dmtl_out_t      expiry_res;

    dmtl_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (rd_addr),
        .rd_data (link_ram_q)
    );

    dmtl_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_addr (rd_addr),
        .rd_data (ent_ram_q)
    );

    // A link never written reads as the next slot of the free chain.
    assign link_rd = rd_valid_reg ? link_ram_q : (IW'(rd_addr_reg) + IW'(1));

    // Tick arithmetic on the entry just read.
    assign ticks_dec = ent_ram_q[EW-1 -: 32] - 32'd1;
    assign expire    = (ticks_dec == 32'd0) || ticks_dec[31];

    // Handle width conversion in both directions.
    assign in_handle_ext  = {{HANDLE_BITS{1'b0}}, item_reg.message_handle};
    assign out_handle_ext = {16'b0, ent_ram_q[HANDLE_BITS-1:0]};

    // Delivery result built from the entry just read.
    always_comb
    begin
        expiry_res            = '0;
        expiry_res.status     = dmtl_pkg::STATUS_DELIVER;
        expiry_res.out_src_id = ent_ram_q[HANDLE_BITS+7 -: 4];
        expiry_res.out_dst_id = ent_ram_q[HANDLE_BITS+3 -: 4];
        expiry_res.out_handle = out_handle_ext[15:0];
        expiry_res.last       = 1'b0;
    end

    assign out_free = !result_valid_reg || result_ready;
    assign stall    = expire && pend_valid_reg && !out_free;

    // Next state, memory accesses and result loading.
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        head_next         = head_reg;
        free_head_next    = free_head_reg;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        fix_pend_next     = fix_pend_reg;
        valid_next        = valid_reg;
        item_ready        = 1'b0;
        rd_addr           = cur_reg[AW-1:0];
        link_wr_en        = 1'b0;
        link_wr_addr      = cur_reg[AW-1:0];
        link_wr_data      = free_head_reg;
        ent_wr_en         = 1'b0;
        ent_wr_addr       = cur_reg[AW-1:0];
        ent_wr_data       = {ticks_dec, ent_ram_q[EW-33:0]};

        unique case (state_reg)
            dmtl_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                rd_addr    = (item.mode == dmtl_pkg::MODE_INSERT) ?
                             free_head_reg[AW-1:0] : head_reg[AW-1:0];
                if (item_valid)
                begin
                    item_next = item;
                    if (item.mode == dmtl_pkg::MODE_INSERT)
                    begin
                        state_next = (free_head_reg == NULL_IDX) ?
                                     dmtl_pkg::ST_FULL : dmtl_pkg::ST_INSERT;
                    end
                    else
                    begin
                        cur_next      = head_reg;
                        prev_next     = NULL_IDX;
                        fix_pend_next = 1'b0;
                        state_next    = (head_reg == NULL_IDX) ?
                                        dmtl_pkg::ST_WALK_END : dmtl_pkg::ST_WALK;
                    end
                end
            end

            // Link the free slot in at the head of the list.
            dmtl_pkg::ST_INSERT:
            begin
                link_wr_en     = 1'b1;
                link_wr_addr   = free_head_reg[AW-1:0];
                link_wr_data   = head_reg;
                ent_wr_en      = 1'b1;
                ent_wr_addr    = free_head_reg[AW-1:0];
                ent_wr_data    = {1'b0, item_reg.delay_ticks, item_reg.src_id,
                                  item_reg.dst_id, in_handle_ext[HANDLE_BITS-1:0]};
                head_next      = free_head_reg;
                free_head_next = link_rd;
                state_next     = dmtl_pkg::ST_IDLE;
            end

            // Report the dropped insert.
            dmtl_pkg::ST_FULL:
            begin
                if (out_free)
                begin
                    result_next        = '0;
                    result_next.status = dmtl_pkg::STATUS_FULL;
                    result_next.last   = 1'b1;
                    result_valid_next  = 1'b1;
                    state_next         = dmtl_pkg::ST_IDLE;
                end
            end

            // One entry per cycle unless stalled; the next read uses the link just read.
            dmtl_pkg::ST_WALK:
            begin
                if (!stall)
                begin
                    ent_wr_en = 1'b1;
                    if (expire)
                    begin
                        // Unlink the slot and push it on the free list.
                        link_wr_en     = 1'b1;
                        link_wr_addr   = cur_reg[AW-1:0];
                        link_wr_data   = free_head_reg;
                        free_head_next = cur_reg;
                        if (prev_reg == NULL_IDX)
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            fix_pend_next = 1'b1;
                        end
                        if (pend_valid_reg)
                        begin
                            result_next       = pend_reg;
                            result_valid_next = 1'b1;
                        end
                        pend_next       = expiry_res;
                        pend_valid_next = 1'b1;
                    end
                    else
                    begin
                        // A survivor closes any gap left behind its predecessor.
                        if (fix_pend_reg)
                        begin
                            link_wr_en    = 1'b1;
                            link_wr_addr  = prev_reg[AW-1:0];
                            link_wr_data  = cur_reg;
                            fix_pend_next = 1'b0;
                        end
                        prev_next = cur_reg;
                    end
                    cur_next = link_rd;
                    rd_addr  = link_rd[AW-1:0];
                    if (link_rd == NULL_IDX)
                    begin
                        state_next = dmtl_pkg::ST_WALK_END;
                    end
                end
            end

            // Terminate the list and release any held final result with last set.
            dmtl_pkg::ST_WALK_END:
            begin
                if (fix_pend_reg)
                begin
                    link_wr_en    = 1'b1;
                    link_wr_addr  = prev_reg[AW-1:0];
                    link_wr_data  = NULL_IDX;
                    fix_pend_next = 1'b0;
                end
                if (!pend_valid_reg)
                begin
                    state_next = dmtl_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    result_next       = pend_reg;
                    result_next.last  = 1'b1;
                    result_valid_next = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = dmtl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dmtl_pkg::ST_IDLE;
            end
        endcase

        // Any written link now holds real data.
        if (link_wr_en)
        begin
            valid_next[link_wr_addr] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dmtl_pkg::ST_IDLE;
            head_reg         <= NULL_IDX;
            free_head_reg    <= '0;
            cur_reg          <= NULL_IDX;
            prev_reg         <= NULL_IDX;
            fix_pend_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            free_head_reg    <= free_head_next;
            cur_reg          <= cur_next;
            prev_reg         <= prev_next;
            fix_pend_reg     <= fix_pend_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            valid_reg        <= valid_next;
            rd_valid_reg     <= valid_reg[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        pend_reg    <= pend_next;
        result_reg  <= result_next;
        rd_addr_reg <= rd_addr;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The pending list and the free list never share their first slot.
    a_lists_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != NULL_IDX && free_head_reg != NULL_IDX) |-> head_reg != free_head_reg)
        else $error("pending list and free list share a head slot");

    // The walk never steps onto the null link.
    a_walk_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmtl_pkg::ST_WALK) |-> cur_reg != NULL_IDX)
        else $error("list walk on null slot");

    // Between items no result is held back and no link repair is owed.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmtl_pkg::ST_IDLE) |-> (!pend_valid_reg && !fix_pend_reg))
        else $error("held result or link repair left over after an item");

    // A stalled expiry holds the walk on the same slot.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmtl_pkg::ST_WALK && stall) |=> (state_reg == dmtl_pkg::ST_WALK
        && cur_reg == $past(cur_reg) && pend_valid_reg))
        else $error("walk advanced while its result could not be stored");

endmodule
